@@ rtl/kbs_pkg.sv @@
package kbs_pkg;

    // op codes of an input beat
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;

    // frame layout in half-bits: start pair, data pairs, parity pair, then stop halves
    localparam int START_HALVES    = 2;
    localparam int DATA_HALF_END   = 18;
    localparam int PARITY_HALF_END = 20;

    // input beat
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] key_code;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic line_bit;
        logic frame_latched;
        logic frame_busy;
    } t_out_beat;

    // classified command from front to back
    typedef struct packed {
        logic       push;
        logic       tick;
        logic       ack;
        logic [7:0] key_code;
    } t_cmd;

endpackage

@@ rtl/kbs_front.sv @@
module kbs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  kbs_pkg::t_in_beat i_in_data,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output kbs_pkg::t_cmd   o_cmd
);

    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    kbs_pkg::t_cmd r_slot [2];
    kbs_pkg::t_cmd w_cmd;
    logic          w_push;
    logic          w_pop;

    // classify the op into one-hot command flags, unused code does nothing
    always_comb begin
        w_cmd          = '0;
        w_cmd.key_code = i_in_data.key_code;
        case (i_in_data.op)
            kbs_pkg::OP_PUSH: w_cmd.push = 1'b1;
            kbs_pkg::OP_TICK: w_cmd.tick = 1'b1;
            kbs_pkg::OP_ACK:  w_cmd.ack  = 1'b1;
            default:          w_cmd      = '0;
        endcase
    end

    // two-entry command queue
    assign o_in_stall  = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/kbs_back.sv @@
module kbs_back #(
    parameter int QUEUE_DEPTH     = 16,
    parameter int STOP_HALF_PAIRS = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  kbs_pkg::t_cmd     i_cmd,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output kbs_pkg::t_out_beat o_out_data
);

    localparam int AW           = $clog2(QUEUE_DEPTH);
    localparam int FRAME_HALVES = kbs_pkg::PARITY_HALF_END + 2 * STOP_HALF_PAIRS;
    localparam int PW           = $clog2(FRAME_HALVES + 2);

    logic [7:0]    r_key_store [QUEUE_DEPTH];
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [7:0]    r_sending_key;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_latch, n_latch;
    logic          r_line, n_line;
    logic          r_out_valid;
    kbs_pkg::t_out_beat r_out;
    logic          w_fire;
    logic          w_start;
    logic [PW-1:0] w_eff_pos;

    // line level of half-bit h for key k
    function automatic logic frame_half(input logic [7:0] k, input logic [PW-1:0] h);
        logic [PW-1:0] hm2;
        logic          bitv;
        hm2  = h - PW'(kbs_pkg::START_HALVES);
        bitv = 1'b0;
        if (h < PW'(kbs_pkg::START_HALVES)) begin
            return (h == '0);
        end
        if (h < PW'(kbs_pkg::DATA_HALF_END)) begin
            bitv = k[hm2[3:1]];
        end else if (h < PW'(kbs_pkg::PARITY_HALF_END)) begin
            bitv = ^k;
        end else begin
            return 1'b0;
        end
        return h[0] ? !bitv : bitv;
    endfunction

    // execute when the result register is free or being drained
    assign o_cmd_ready = !r_out_valid || !i_out_stall;
    assign w_fire      = i_cmd_valid && o_cmd_ready;
    assign w_start     = i_cmd.tick && (r_head != r_tail) && (r_pos == '0) && !r_latch;
    assign w_eff_pos   = w_start ? PW'(1) : r_pos;

    // next state of the link
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_pos   = r_pos;
        n_latch = r_latch;
        n_line  = r_line;
        if (i_cmd.push) begin
            n_tail = (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_cmd.tick) begin
            if (w_start) begin
                n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_latch = 1'b1;
            end
            if (w_eff_pos != '0) begin
                n_line = frame_half(r_sending_key, w_eff_pos - 1'b1);
                n_pos  = (w_eff_pos == PW'(FRAME_HALVES)) ? '0 : w_eff_pos + 1'b1;
            end
        end
        if (i_cmd.ack) begin
            n_latch = 1'b0;
        end
    end

    // key store write on push, registered read on frame start
    always_ff @(posedge i_clk) begin
        if (w_fire && i_cmd.push) begin
            r_key_store[r_tail] <= i_cmd.key_code;
        end
        if (w_fire && w_start) begin
            r_sending_key <= r_key_store[r_head];
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.line_bit      <= n_line;
            r_out.frame_latched <= n_latch;
            r_out.frame_busy    <= (n_pos != '0);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_pos       <= '0;
            r_latch     <= 1'b0;
            r_line      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_pos   <= n_pos;
                r_latch <= n_latch;
                r_line  <= n_line;
            end
            if (o_cmd_ready) begin
                r_out_valid <= i_cmd_valid;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/keyboard_biphase_frame_serializer_unit.sv @@
// keyboard bi-phase frame serializer
// input channel (i_in_valid / o_in_stall / i_in_data) takes one op per beat:
// push a key byte into the circular key queue, tick one half-bit time, or
// acknowledge the latched key. output channel (o_out_valid / i_out_stall /
// o_out_data) returns one beat per input beat: line level, latch and busy.
// a frame is 20 + 2*STOP_HALF_PAIRS half-bits, one per tick.
// a result is offered once its input beat has passed the front command queue
// and then the back result register.
// throughput: one beat per cycle unless the receiver stalls, set by the
// back state update; front queue and result register decouple the sides.
// reset: key queue empty, line low, latch clear, no frame, no beats pending.
// when the receiver stalls the result beat holds, the front queue fills and
// o_in_stall rises once it holds two commands.
module keyboard_biphase_frame_serializer_unit #(
    parameter int QUEUE_DEPTH     = 16,
    parameter int STOP_HALF_PAIRS = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kbs_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kbs_pkg::t_out_beat o_out_data
);

    logic          w_cmd_valid;
    logic          w_cmd_ready;
    kbs_pkg::t_cmd w_cmd;

    // classify and queue
    kbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // key queue and frame shifter
    kbs_back #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .STOP_HALF_PAIRS (STOP_HALF_PAIRS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sim/keyboard_biphase_frame_serializer_unit_tb.sv @@
`timescale 1ns / 100ps

module keyboard_biphase_frame_serializer_unit_tb;

    localparam int RING_DEPTH   = 16;
    localparam int STOP_PAIRS   = 11;
    localparam int FRAME_HALVES = kbs_pkg::PARITY_HALF_END + 2 * STOP_PAIRS;
    localparam int ITEMS        = 1150;
    localparam int QUIET_TAIL   = 200;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 80;

    // op code with no function, the block ignores it
    localparam logic [1:0] OP_SPARE = 2'd3;

    // a queued command, optionally held back until all line states are back
    typedef struct packed {
        logic              drain;
        kbs_pkg::t_in_beat beat;
    } t_pending_beat;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    kbs_pkg::t_in_beat  i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    kbs_pkg::t_out_beat o_out_data;

    t_pending_beat      pending_cmd_q[$];
    kbs_pkg::t_out_beat line_expect_q[$];
    int                 err_count = 0;
    logic               drain_next = 1'b0;

    // serializer shadow state
    logic [7:0] key_ring [RING_DEPTH];
    logic [3:0] ring_head = '0;
    logic [3:0] ring_tail = '0;
    logic [7:0] cur_key   = '0;
    int         half_pos  = 0;
    logic       latch     = 1'b0;
    logic       line      = 1'b0;

    keyboard_biphase_frame_serializer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // line level of half-bit h of the frame for key k
    function automatic logic half_level(logic [7:0] k, int h);
        logic b;
        if (h < kbs_pkg::START_HALVES) begin
            return (h == 0);
        end
        if (h < kbs_pkg::DATA_HALF_END) begin
            b = k[(h - kbs_pkg::START_HALVES) >> 1];
        end else if (h < kbs_pkg::PARITY_HALF_END) begin
            b = ^k;
        end else begin
            return 1'b0;
        end
        return h[0] ? ~b : b;
    endfunction

    // advance the shadow serializer by one command and queue the line state
    function automatic void predict_line_state(kbs_pkg::t_in_beat b);
        kbs_pkg::t_out_beat r;
        case (b.op)
            kbs_pkg::OP_PUSH: begin
                key_ring[ring_tail] = b.key_code;
                ring_tail = ring_tail + 4'd1;
            end
            kbs_pkg::OP_TICK: begin
                if (ring_head != ring_tail && half_pos == 0 && !latch) begin
                    cur_key   = key_ring[ring_head];
                    ring_head = ring_head + 4'd1;
                    latch     = 1'b1;
                    half_pos  = 1;
                end
                if (half_pos != 0) begin
                    line     = half_level(cur_key, half_pos - 1);
                    half_pos = half_pos + 1;
                    if (half_pos >= FRAME_HALVES + 1) begin
                        half_pos = 0;
                    end
                end
            end
            kbs_pkg::OP_ACK: begin
                latch = 1'b0;
            end
            default: ;
        endcase
        r.line_bit      = line;
        r.frame_latched = latch;
        r.frame_busy    = (half_pos != 0);
        line_expect_q.push_back(r);
    endfunction

    function automatic void queue_cmd(logic [1:0] op, logic [7:0] key);
        t_pending_beat p;
        p.drain         = drain_next;
        p.beat.op       = op;
        p.beat.key_code = key;
        drain_next      = 1'b0;
        pending_cmd_q.push_back(p);
    endfunction

    // command driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_line_state(i_in_data);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_cmd_q.size() == 0 ||
                             (pending_cmd_q[0].drain && line_expect_q.size() != 0)) begin
                    i_in_valid <= 1'b0;
                end else if (pending_cmd_q.size() > QUIET_TAIL &&
                             $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 8) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_cmd_q[0].beat;
                    pending_cmd_q.pop_front();
                end
            end
        end
    end

    // line state monitor and receiver stalls
    int  stall_left      = 0;
    int  results_checked = 0;
    logic long_hold_done = 1'b0;
    always @(posedge i_clk) begin : result_monitor
        kbs_pkg::t_out_beat want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (line_expect_q.size() == 0) begin
                    $error("result beat with no expectation: %b", o_out_data);
                    err_count++;
                end else begin
                    want = line_expect_q.pop_front();
                    if (o_out_data.line_bit !== want.line_bit) begin
                        $error("line_bit: expected %b, got %b",
                               want.line_bit, o_out_data.line_bit);
                        err_count++;
                    end
                    if (o_out_data.frame_latched !== want.frame_latched) begin
                        $error("frame_latched: expected %b, got %b",
                               want.frame_latched, o_out_data.frame_latched);
                        err_count++;
                    end
                    if (o_out_data.frame_busy !== want.frame_busy) begin
                        $error("frame_busy: expected %b, got %b",
                               want.frame_busy, o_out_data.frame_busy);
                        err_count++;
                    end
                end
                results_checked++;
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (!long_hold_done && results_checked >= 400) begin
                // one long hold so the front queue fills and stalls the sender
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else if (pending_cmd_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no beat moving
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int n_keys;
        int n_ticks;
        int ack_at;
        int pick;
        int n;
        logic drained;
        drained = 1'b0;

        // directed: unused op, idle ack, empty tick, extreme keys, ack mid-frame
        queue_cmd(OP_SPARE, 8'hff);
        queue_cmd(kbs_pkg::OP_ACK, 8'h00);
        queue_cmd(kbs_pkg::OP_TICK, 8'h00);
        queue_cmd(kbs_pkg::OP_PUSH, 8'hff);
        queue_cmd(kbs_pkg::OP_PUSH, 8'h00);
        queue_cmd(kbs_pkg::OP_PUSH, 8'h01);
        queue_cmd(kbs_pkg::OP_PUSH, 8'h80);
        queue_cmd(kbs_pkg::OP_TICK, 8'h00);
        queue_cmd(kbs_pkg::OP_TICK, 8'hff);
        queue_cmd(kbs_pkg::OP_ACK, 8'h00);
        queue_cmd(kbs_pkg::OP_ACK, 8'hff);
        repeat (13) queue_cmd(kbs_pkg::OP_TICK, 8'h00);

        // random: mostly whole frames, some queue wraps, some noise
        while (pending_cmd_q.size() < ITEMS) begin
            if (!drained && pending_cmd_q.size() >= 600) begin
                drained    = 1'b1;
                drain_next = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                n_keys = $urandom_range(1, 3);
                repeat (n_keys) queue_cmd(kbs_pkg::OP_PUSH, 8'($urandom_range(0, 255)));
                repeat (n_keys) begin
                    n_ticks = $urandom_range(FRAME_HALVES, FRAME_HALVES + 4);
                    ack_at  = $urandom_range(0, n_ticks);
                    for (int t = 0; t < n_ticks; t++) begin
                        if (t == ack_at) begin
                            queue_cmd(kbs_pkg::OP_ACK, 8'($urandom_range(0, 255)));
                        end
                        queue_cmd(kbs_pkg::OP_TICK, 8'($urandom_range(0, 255)));
                    end
                    if (ack_at == n_ticks) begin
                        queue_cmd(kbs_pkg::OP_ACK, 8'($urandom_range(0, 255)));
                    end
                end
            end else if (pick < 8) begin
                // fill the ring to and past its depth
                n = $urandom_range(RING_DEPTH - 1, RING_DEPTH + 1);
                repeat (n) queue_cmd(kbs_pkg::OP_PUSH, 8'($urandom_range(0, 255)));
            end else begin
                n = $urandom_range(3, 10);
                repeat (n) queue_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmd_q.size() != 0 || i_in_valid || line_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
